// ===== sv/gmps_pkg.sv =====
// shared widths, register indexes and sequencer states for the grid min path sum unit
package gmps_pkg;

   localparam int CFG_W    = 6;
   localparam int EFF_W    = CFG_W + 1;
   localparam int WEIGHT_W = 16;
   localparam int SUM_W    = 22;
   localparam int IDX_W    = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED = 1'd1;

   localparam logic [CFG_W-1:0] ROWS_USED_RESET = 6'd32;
   localparam logic [CFG_W-1:0] COLS_USED_RESET = 6'd32;

   typedef enum logic [1:0] {
      ST_CELL,
      ST_TRACE_RD,
      ST_TRACE_EMIT
   } gmps_state_type;

endpackage

// ===== sv/gmps_req_if.sv =====
// cell weight channel
interface gmps_req_if
   import gmps_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] cell_weight;

   modport source (output valid, output cell_weight, input ready);
   modport sink   (input valid, input cell_weight, output ready);
endinterface

// ===== sv/gmps_rsp_if.sv =====
// path result channel
interface gmps_rsp_if
   import gmps_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] path_row;
   logic [IDX_W-1:0] path_col;
   logic [SUM_W-1:0] total_cost;
   logic             last_step;

   modport source (output valid, output path_row, output path_col, output total_cost,
                   output last_step, input ready);
   modport sink   (input valid, input path_row, input path_col, input total_cost,
                   input last_step, output ready);
endinterface

// ===== sv/gmps_dir_ram.sv =====
// direction bit store, one write and one registered read port
module gmps_dir_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_bit,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_bit
);

   logic mem [DEPTH];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_bit;
      end
      rd_bit_ff <= mem[rd_addr];
   end

   assign rd_bit = rd_bit_ff;

endmodule

// ===== sv/grid_min_path_sum_unit.sv =====
// grid min path sum unit: streamed dp over grid cells, then path traceback
// cells are taken one per cycle; each uses the line buffer, one compare and one add
// after the last cell the traceback emits rows+cols-1 words, each a direction bit
// ram read, then output register load once the slot frees; no cells taken meanwhile
// synchronous active-high reset: sizes 32x32 clamped to the maximums, grid restarts
module grid_min_path_sum_unit
   import gmps_pkg::*;
#(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   gmps_req_if.sink             req_ch,
   gmps_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COLS_RESET_EFF = (MAX_COLS < 32) ? MAX_COLS : 32;
   localparam logic [CW-1:0] COL_RESET = CW'(COLS_RESET_EFF - 1);

   gmps_state_type state_ff, state_in;

   logic [CFG_W-1:0] rows_used_ff, rows_used_in;
   logic [CFG_W-1:0] cols_used_ff, cols_used_in;
   logic [RW-1:0]    row_count_ff, row_count_in;
   logic [CW-1:0]    col_count_ff, col_count_in;
   logic [SUM_W-1:0] right_sum_ff, right_sum_in;
   logic [SUM_W-1:0] final_sum_ff;
   logic [SUM_W-1:0] prev_sums_ff [MAX_COLS];
   logic [RW-1:0]    trace_row_ff, trace_row_in;
   logic [CW-1:0]    trace_col_ff, trace_col_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_row_ff;
   logic [IDX_W-1:0] rsp_col_ff;
   logic [SUM_W-1:0] rsp_cost_ff;
   logic             rsp_last_ff;

   logic [EFF_W-1:0] rows_eff, cols_eff;
   logic [RW-1:0]    rows_last;
   logic [CW-1:0]    cols_last;

   logic             cell_take;
   logic             last_cell;
   logic [SUM_W-1:0] up_sum;
   logic [SUM_W-1:0] base_sum;
   logic [SUM_W-1:0] cell_sum;
   logic             cell_up;

   logic             slot_free;
   logic             trace_last;
   logic             emit_go;
   logic             dir_bit;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;

   // register clamping: zero counts as one, anything above the maximum as the maximum
   always_comb begin
      if (rows_used_ff == '0) begin
         rows_eff = EFF_W'(1);
      end else if (EFF_W'(rows_used_ff) > EFF_W'(MAX_ROWS)) begin
         rows_eff = EFF_W'(MAX_ROWS);
      end else begin
         rows_eff = EFF_W'(rows_used_ff);
      end
      if (cols_used_ff == '0) begin
         cols_eff = EFF_W'(1);
      end else if (EFF_W'(cols_used_ff) > EFF_W'(MAX_COLS)) begin
         cols_eff = EFF_W'(MAX_COLS);
      end else begin
         cols_eff = EFF_W'(cols_used_ff);
      end
      rows_last = RW'(rows_eff - EFF_W'(1));
      cols_last = CW'(cols_eff - EFF_W'(1));
   end

   // cell datapath: one compare and one add against the line buffer
   always_comb begin
      up_sum = prev_sums_ff[col_count_ff];
      if (row_count_ff == '0) begin
         cell_up  = 1'b0;
         base_sum = (col_count_ff == cols_last) ? '0 : right_sum_ff;
      end else if (col_count_ff == cols_last) begin
         cell_up  = 1'b1;
         base_sum = up_sum;
      end else if (up_sum <= right_sum_ff) begin
         cell_up  = 1'b1;
         base_sum = up_sum;
      end else begin
         cell_up  = 1'b0;
         base_sum = right_sum_ff;
      end
      cell_sum  = base_sum + SUM_W'(req_ch.cell_weight);
      last_cell = (col_count_ff == '0) && (row_count_ff == rows_last);
      wr_addr   = AW'(int'(row_count_ff) * MAX_COLS + int'(col_count_ff));
      rd_addr   = AW'(int'(trace_row_ff) * MAX_COLS + int'(trace_col_ff));
   end

   assign slot_free  = !rsp_valid_ff || rsp_ch.ready;
   assign trace_last = (trace_row_ff == '0) && (trace_col_ff == cols_last);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CELL: begin
            if (req_ch.valid && last_cell) begin
               state_in = ST_TRACE_RD;
            end
         end
         ST_TRACE_RD: begin
            state_in = ST_TRACE_EMIT;
         end
         ST_TRACE_EMIT: begin
            if (slot_free) begin
               state_in = trace_last ? ST_CELL : ST_TRACE_RD;
            end
         end
         default: begin
            state_in = ST_CELL;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready = 1'b0;
      emit_go      = 1'b0;
      case (state_ff)
         ST_CELL: begin
            req_ch.ready = 1'b1;
         end
         ST_TRACE_RD: begin
            req_ch.ready = 1'b0;
         end
         ST_TRACE_EMIT: begin
            emit_go = slot_free;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   assign cell_take = req_ch.valid && req_ch.ready;

   // grid counters, config and traceback position
   always_comb begin
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      right_sum_in = right_sum_ff;
      trace_row_in = trace_row_ff;
      trace_col_in = trace_col_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_ROWS_USED: rows_used_in = csr_wdata;
            CSR_COLS_USED: cols_used_in = csr_wdata;
            default:       rows_used_in = rows_used_ff;
         endcase
         row_count_in = '0;
         col_count_in = (csr_index == CSR_COLS_USED)
                      ? CW'(((csr_wdata == '0) ? EFF_W'(1)
                           : (EFF_W'(csr_wdata) > EFF_W'(MAX_COLS)) ? EFF_W'(MAX_COLS)
                           : EFF_W'(csr_wdata)) - EFF_W'(1))
                      : cols_last;
         right_sum_in = '0;
      end else if (cell_take) begin
         if (col_count_ff != '0) begin
            col_count_in = col_count_ff - CW'(1);
            right_sum_in = cell_sum;
         end else begin
            // row end, or grid end which also starts the walk
            row_count_in = last_cell ? '0 : row_count_ff + RW'(1);
            col_count_in = cols_last;
            right_sum_in = '0;
            if (last_cell) begin
               trace_row_in = rows_last;
               trace_col_in = '0;
            end
         end
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         if (!trace_last) begin
            if (trace_col_ff != cols_last && (trace_row_ff == '0 || !dir_bit)) begin
               trace_col_in = trace_col_ff + CW'(1);
            end else if (trace_row_ff != '0) begin
               trace_row_in = trace_row_ff - RW'(1);
            end else begin
               trace_col_in = trace_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CELL;
         rows_used_ff <= ROWS_USED_RESET;
         cols_used_ff <= COLS_USED_RESET;
         row_count_ff <= '0;
         col_count_ff <= COL_RESET;
         right_sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
         final_sum_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         right_sum_ff <= right_sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cell_take && last_cell) begin
            final_sum_ff <= cell_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      trace_row_ff <= trace_row_in;
      trace_col_ff <= trace_col_in;
      if (cell_take) begin
         prev_sums_ff[col_count_ff] <= cell_sum;
      end
      if (emit_go) begin
         rsp_row_ff  <= IDX_W'(trace_row_ff);
         rsp_col_ff  <= IDX_W'(trace_col_ff);
         rsp_cost_ff <= final_sum_ff;
         rsp_last_ff <= trace_last;
      end
   end

   gmps_dir_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (cell_take),
      .wr_addr (wr_addr),
      .wr_bit  (cell_up),
      .rd_addr (rd_addr),
      .rd_bit  (dir_bit)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.path_row   = rsp_row_ff;
   assign rsp_ch.path_col   = rsp_col_ff;
   assign rsp_ch.total_cost = rsp_cost_ff;
   assign rsp_ch.last_step  = rsp_last_ff;

endmodule
